>>> hdl/cpec_pkg.sv
// Shared types and constants for the circle pair elastic collision core.
package cpec_pkg;

    localparam int SQ_STEPS  = 25;   // one root bit per stage, 50-bit radicand
    localparam int DIV_STEPS = 32;   // one quotient bit per stage

    localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

    // Input fields carried unchanged down the pipe.
    typedef struct packed {
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic        [31:0] ma;
        logic        [31:0] mb;
        logic        [24:0] rsum;
    } t_pass;

    typedef struct packed {
        t_pass              p;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } t_s0;

    typedef struct packed {
        t_pass              p;
        logic signed [25:0] dx;
        logic signed [25:0] dy;
        logic        [49:0] dx2;
        logic        [49:0] dy2;
        logic        [49:0] r2;
        logic               inr;
    } t_s1;

    typedef struct packed {
        t_pass              p;
        logic signed [25:0] dx;
        logic signed [25:0] dy;
        logic               hit;
        logic        [49:0] v;
        logic        [50:0] res;
    } t_sq;

    typedef struct packed {
        t_pass       p;
        logic        hit;
        logic        mz;
        logic        sx;
        logic        sy;
        logic [24:0] dlen;
        logic [32:0] mt;
        logic [65:0] wx;
        logic [65:0] wy;
        logic [65:0] wa;
        logic [65:0] wb;
    } t_dv;

    typedef struct packed {
        t_pass              p;
        logic               hit;
        logic               mz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [63:0] pa;
        logic signed [63:0] pb;
        logic signed [63:0] pc;
        logic signed [63:0] pd;
        logic signed [57:0] ox;
        logic signed [57:0] oy;
        logic        [31:0] ra;
        logic        [31:0] rb;
    } t_p1;

    typedef struct packed {
        t_pass              p;
        logic               hit;
        logic               mz;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [26:0] hx;
        logic signed [26:0] hy;
    } t_tl;

    typedef struct packed {
        t_tl                tl;
        logic signed [31:0] van;
        logic signed [31:0] vbn;
        logic        [31:0] ra;
        logic        [31:0] rb;
    } t_p2;

    typedef struct packed {
        t_tl                tl;
        logic signed [65:0] qa;
        logic signed [65:0] qb;
    } t_p3;

    typedef struct packed {
        t_tl                tl;
        logic signed [35:0] da;
        logic signed [35:0] db;
    } t_p4;

    typedef struct packed {
        t_tl                tl;
        logic signed [67:0] max;
        logic signed [67:0] may;
        logic signed [67:0] mbx;
        logic signed [67:0] mby;
    } t_p5;

    typedef struct packed {
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic               hit;
    } t_out;

endpackage

>>> hdl/circle_pair_elastic_collision_core.sv
// Two-circle elastic collision resolver, pipelined, signed Q16.16.
// Throughput: one request per cycle while the output is not stalled; the root and
// the dividers each retire one bit a stage.
// A stalled output holds only the stages behind it that are full; bubbles close up.
// Reset clears the stage valid bits only; payload registers hold whatever they had.
module circle_pair_elastic_collision_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_a_x,
    input  logic signed [31:0] i_pos_a_y,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic        [23:0] i_radius_a,
    input  logic        [31:0] i_mass_a,
    input  logic signed [31:0] i_pos_b_x,
    input  logic signed [31:0] i_pos_b_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic        [23:0] i_radius_b,
    input  logic        [31:0] i_mass_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_new_pos_a_x,
    output logic signed [31:0] o_new_pos_a_y,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_pos_b_x,
    output logic signed [31:0] o_new_pos_b_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output logic               o_collided
);

    // Stage map: deltas, squares, root (seed + one bit per stage),
    // dividers (seed + one bit per stage), then the five product stages and output.
    localparam int SQN    = cpec_pkg::SQ_STEPS;
    localparam int DVN    = cpec_pkg::DIV_STEPS;
    localparam int IX_SQ  = 2;
    localparam int IX_DV  = IX_SQ + SQN + 1;
    localparam int IX_P1  = IX_DV + DVN + 1;
    localparam int IX_P2  = IX_P1 + 1;
    localparam int IX_P3  = IX_P2 + 1;
    localparam int IX_P4  = IX_P3 + 1;
    localparam int IX_P5  = IX_P4 + 1;
    localparam int IX_OUT = IX_P5 + 1;
    localparam int NST    = IX_OUT + 1;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        if (x > cpec_pkg::SAT_MAX) return 32'sh7FFFFFFF;
        if (x < cpec_pkg::SAT_MIN) return -32'sh80000000;
        return x[31:0];
    endfunction

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [65:0] div_step(input logic [65:0] w, input logic [33:0] d);
        logic [65:0] t;
        t = {w[64:0], 1'b0};
        if (t[65:32] >= d) begin
            t[65:32] = t[65:32] - d;
            t[0]     = 1'b1;
        end
        return t;
    endfunction

    // ---------------- valid / ready chain ----------------
    // A stage takes a new request when it is empty or its own holder moves on.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   rdy;

    assign rdy[NST] = i_ready;
    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_rdy
            assign rdy[s] = !r_vld[s] || rdy[s+1];
        end
    endgenerate

    assign n_vld   = {r_vld[NST-2:0], i_valid};
    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) r_vld[k] <= n_vld[k];
            end
        end
    end

    // ---------------- stage 0: center deltas, radius sum ----------------
    cpec_pkg::t_s0 r_s0;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0.p.pax  <= i_pos_a_x;
            r_s0.p.pay  <= i_pos_a_y;
            r_s0.p.vax  <= i_vel_a_x;
            r_s0.p.vay  <= i_vel_a_y;
            r_s0.p.pbx  <= i_pos_b_x;
            r_s0.p.pby  <= i_pos_b_y;
            r_s0.p.vbx  <= i_vel_b_x;
            r_s0.p.vby  <= i_vel_b_y;
            r_s0.p.ma   <= i_mass_a;
            r_s0.p.mb   <= i_mass_b;
            r_s0.p.rsum <= 25'(i_radius_a) + 25'(i_radius_b);
            r_s0.dx     <= 33'(i_pos_b_x) - 33'(i_pos_a_x);
            r_s0.dy     <= 33'(i_pos_b_y) - 33'(i_pos_a_y);
        end
    end

    // ---------------- stage 1: box test and squares ----------------
    // Inside the box both deltas fit 25 bits, so the squares are exact there.
    cpec_pkg::t_s1 r_s1;
    logic [32:0] c_ax, c_ay;

    assign c_ax = r_s0.dx[32] ? 33'(-r_s0.dx) : 33'(r_s0.dx);
    assign c_ay = r_s0.dy[32] ? 33'(-r_s0.dy) : 33'(r_s0.dy);

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1.p   <= r_s0.p;
            r_s1.dx  <= r_s0.dx[25:0];
            r_s1.dy  <= r_s0.dy[25:0];
            r_s1.dx2 <= c_ax[24:0] * c_ax[24:0];
            r_s1.dy2 <= c_ay[24:0] * c_ay[24:0];
            r_s1.r2  <= r_s0.p.rsum * r_s0.p.rsum;
            r_s1.inr <= (c_ax < 33'(r_s0.p.rsum)) && (c_ay < 33'(r_s0.p.rsum));
        end
    end

    // ---------------- stage 2: distance squared, hit flag, root seed ----------------
    cpec_pkg::t_sq r_sq [SQN+1];
    logic [50:0] c_d2;

    assign c_d2 = {1'b0, r_s1.dx2} + {1'b0, r_s1.dy2};

    always_ff @(posedge i_clk) begin
        if (rdy[IX_SQ]) begin
            r_sq[0].p   <= r_s1.p;
            r_sq[0].dx  <= r_s1.dx;
            r_sq[0].dy  <= r_s1.dy;
            r_sq[0].hit <= r_s1.inr && (c_d2 != '0) && (c_d2 < {1'b0, r_s1.r2});
            r_sq[0].v   <= c_d2[49:0];
            r_sq[0].res <= '0;
        end
    end

    // ---------------- integer square root, one bit per stage ----------------
    genvar k;
    generate
        for (k = 0; k < SQN; k++) begin : g_sq
            localparam logic [50:0] BITC = 51'(1) << (2 * (SQN - 1 - k));
            logic [50:0] c_tr;
            assign c_tr = r_sq[k].res + BITC;

            always_ff @(posedge i_clk) begin
                if (rdy[IX_SQ+1+k]) begin
                    r_sq[k+1].p   <= r_sq[k].p;
                    r_sq[k+1].dx  <= r_sq[k].dx;
                    r_sq[k+1].dy  <= r_sq[k].dy;
                    r_sq[k+1].hit <= r_sq[k].hit;
                    if ({1'b0, r_sq[k].v} >= c_tr) begin
                        r_sq[k+1].v   <= r_sq[k].v - c_tr[49:0];
                        r_sq[k+1].res <= (r_sq[k].res >> 1) + BITC;
                    end else begin
                        r_sq[k+1].v   <= r_sq[k].v;
                        r_sq[k+1].res <= r_sq[k].res >> 1;
                    end
                end
            end
        end
    endgenerate

    // ---------------- divider seed ----------------
    // Each lane holds {remainder, dividend tail}; the tail fills with quotient bits.
    // Normal lanes divide |d|*2^30 by the distance, mass lanes 2*m*2^30 by the mass sum.
    cpec_pkg::t_dv r_dv [DVN+1];
    logic [24:0] c_mx, c_my;
    logic [32:0] c_mt;

    assign c_mx = r_sq[SQN].dx[25] ? 25'(-r_sq[SQN].dx) : 25'(r_sq[SQN].dx);
    assign c_my = r_sq[SQN].dy[25] ? 25'(-r_sq[SQN].dy) : 25'(r_sq[SQN].dy);
    assign c_mt = 33'(r_sq[SQN].p.ma) + 33'(r_sq[SQN].p.mb);

    always_ff @(posedge i_clk) begin
        if (rdy[IX_DV]) begin
            r_dv[0].p    <= r_sq[SQN].p;
            r_dv[0].hit  <= r_sq[SQN].hit;
            r_dv[0].mz   <= (c_mt == '0);
            r_dv[0].sx   <= r_sq[SQN].dx[25];
            r_dv[0].sy   <= r_sq[SQN].dy[25];
            r_dv[0].dlen <= r_sq[SQN].res[24:0];
            r_dv[0].mt   <= c_mt;
            r_dv[0].wx   <= {34'(c_mx >> 2), c_mx[1:0], 30'b0};
            r_dv[0].wy   <= {34'(c_my >> 2), c_my[1:0], 30'b0};
            r_dv[0].wa   <= {34'(r_sq[SQN].p.ma >> 1), r_sq[SQN].p.ma[0], 31'b0};
            r_dv[0].wb   <= {34'(r_sq[SQN].p.mb >> 1), r_sq[SQN].p.mb[0], 31'b0};
        end
    end

    generate
        for (k = 0; k < DVN; k++) begin : g_dv
            always_ff @(posedge i_clk) begin
                if (rdy[IX_DV+1+k]) begin
                    r_dv[k+1].p    <= r_dv[k].p;
                    r_dv[k+1].hit  <= r_dv[k].hit;
                    r_dv[k+1].mz   <= r_dv[k].mz;
                    r_dv[k+1].sx   <= r_dv[k].sx;
                    r_dv[k+1].sy   <= r_dv[k].sy;
                    r_dv[k+1].dlen <= r_dv[k].dlen;
                    r_dv[k+1].mt   <= r_dv[k].mt;
                    r_dv[k+1].wx   <= div_step(r_dv[k].wx, 34'(r_dv[k].dlen));
                    r_dv[k+1].wy   <= div_step(r_dv[k].wy, 34'(r_dv[k].dlen));
                    r_dv[k+1].wa   <= div_step(r_dv[k].wa, 34'(r_dv[k].mt));
                    r_dv[k+1].wb   <= div_step(r_dv[k].wb, 34'(r_dv[k].mt));
                end
            end
        end
    endgenerate

    // ---------------- P1: unit normal, projections, push products ----------------
    cpec_pkg::t_p1      r_p1;
    logic signed [31:0] c_nx, c_ny;
    logic signed [25:0] c_ov;

    assign c_nx = r_dv[DVN].sx ? -$signed(r_dv[DVN].wx[31:0]) : $signed(r_dv[DVN].wx[31:0]);
    assign c_ny = r_dv[DVN].sy ? -$signed(r_dv[DVN].wy[31:0]) : $signed(r_dv[DVN].wy[31:0]);
    assign c_ov = $signed({1'b0, r_dv[DVN].p.rsum}) - $signed({1'b0, r_dv[DVN].dlen});

    always_ff @(posedge i_clk) begin
        if (rdy[IX_P1]) begin
            r_p1.p   <= r_dv[DVN].p;
            r_p1.hit <= r_dv[DVN].hit;
            r_p1.mz  <= r_dv[DVN].mz;
            r_p1.nx  <= c_nx;
            r_p1.ny  <= c_ny;
            r_p1.pa  <= r_dv[DVN].p.vax * c_nx;
            r_p1.pb  <= r_dv[DVN].p.vay * c_ny;
            r_p1.pc  <= r_dv[DVN].p.vbx * c_nx;
            r_p1.pd  <= r_dv[DVN].p.vby * c_ny;
            r_p1.ox  <= c_ov * c_nx;
            r_p1.oy  <= c_ov * c_ny;
            r_p1.ra  <= r_dv[DVN].wa[31:0];
            r_p1.rb  <= r_dv[DVN].wb[31:0];
        end
    end

    // ---------------- P2: normal speeds, half-overlap push ----------------
    cpec_pkg::t_p2      r_p2;
    logic signed [63:0] c_sa, c_sb;

    assign c_sa = r_p1.pa + r_p1.pb;
    assign c_sb = r_p1.pc + r_p1.pd;

    always_ff @(posedge i_clk) begin
        if (rdy[IX_P2]) begin
            r_p2.tl.p   <= r_p1.p;
            r_p2.tl.hit <= r_p1.hit;
            r_p2.tl.mz  <= r_p1.mz;
            r_p2.tl.nx  <= r_p1.nx;
            r_p2.tl.ny  <= r_p1.ny;
            r_p2.tl.hx  <= 27'(r_p1.ox >>> 31);
            r_p2.tl.hy  <= 27'(r_p1.oy >>> 31);
            r_p2.van    <= sat32(40'(c_sa >>> 30));
            r_p2.vbn    <= sat32(40'(c_sb >>> 30));
            r_p2.ra     <= r_p1.ra;
            r_p2.rb     <= r_p1.rb;
        end
    end

    // ---------------- P3: mass-weighted speed exchange ----------------
    cpec_pkg::t_p3      r_p3;
    logic signed [32:0] c_dv;

    assign c_dv = 33'(r_p2.vbn) - 33'(r_p2.van);

    always_ff @(posedge i_clk) begin
        if (rdy[IX_P3]) begin
            r_p3.tl <= r_p2.tl;
            r_p3.qa <= $signed({1'b0, r_p2.rb}) * c_dv;
            r_p3.qb <= $signed({1'b0, r_p2.ra}) * (-c_dv);
        end
    end

    // ---------------- P4: rescale speed changes ----------------
    cpec_pkg::t_p4 r_p4;

    always_ff @(posedge i_clk) begin
        if (rdy[IX_P4]) begin
            r_p4.tl <= r_p3.tl;
            r_p4.da <= 36'(r_p3.qa >>> 30);
            r_p4.db <= 36'(r_p3.qb >>> 30);
        end
    end

    // ---------------- P5: speed change along the normal ----------------
    cpec_pkg::t_p5 r_p5;

    always_ff @(posedge i_clk) begin
        if (rdy[IX_P5]) begin
            r_p5.tl  <= r_p4.tl;
            r_p5.max <= r_p4.da * r_p4.tl.nx;
            r_p5.may <= r_p4.da * r_p4.tl.ny;
            r_p5.mbx <= r_p4.db * r_p4.tl.nx;
            r_p5.mby <= r_p4.db * r_p4.tl.ny;
        end
    end

    // ---------------- output register ----------------
    // Pass the pair unchanged on a miss; hold velocities when both masses are zero.
    cpec_pkg::t_out r_out;
    logic           c_kv;

    assign c_kv = !r_p5.tl.hit || r_p5.tl.mz;

    always_ff @(posedge i_clk) begin
        if (rdy[IX_OUT]) begin
            r_out.hit <= r_p5.tl.hit;
            r_out.vax <= c_kv ? r_p5.tl.p.vax
                              : sat32(40'(r_p5.tl.p.vax) + 40'(r_p5.max >>> 30));
            r_out.vay <= c_kv ? r_p5.tl.p.vay
                              : sat32(40'(r_p5.tl.p.vay) + 40'(r_p5.may >>> 30));
            r_out.vbx <= c_kv ? r_p5.tl.p.vbx
                              : sat32(40'(r_p5.tl.p.vbx) + 40'(r_p5.mbx >>> 30));
            r_out.vby <= c_kv ? r_p5.tl.p.vby
                              : sat32(40'(r_p5.tl.p.vby) + 40'(r_p5.mby >>> 30));
            r_out.pax <= !r_p5.tl.hit ? r_p5.tl.p.pax
                              : sat32(40'(r_p5.tl.p.pax) - 40'(r_p5.tl.hx));
            r_out.pay <= !r_p5.tl.hit ? r_p5.tl.p.pay
                              : sat32(40'(r_p5.tl.p.pay) - 40'(r_p5.tl.hy));
            r_out.pbx <= !r_p5.tl.hit ? r_p5.tl.p.pbx
                              : sat32(40'(r_p5.tl.p.pbx) + 40'(r_p5.tl.hx));
            r_out.pby <= !r_p5.tl.hit ? r_p5.tl.p.pby
                              : sat32(40'(r_p5.tl.p.pby) + 40'(r_p5.tl.hy));
        end
    end

    assign o_new_pos_a_x = r_out.pax;
    assign o_new_pos_a_y = r_out.pay;
    assign o_new_vel_a_x = r_out.vax;
    assign o_new_vel_a_y = r_out.vay;
    assign o_new_pos_b_x = r_out.pbx;
    assign o_new_pos_b_y = r_out.pby;
    assign o_new_vel_b_x = r_out.vbx;
    assign o_new_vel_b_y = r_out.vby;
    assign o_collided    = r_out.hit;

endmodule

>>> verif/circle_pair_elastic_collision_checker.sv
// Scoreboard for the collision core: predicts each request and checks every result.
`timescale 1ns / 1ps

module circle_pair_elastic_collision_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [31:0] i_pos_a_x,
    input  logic signed [31:0] i_pos_a_y,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic        [23:0] i_radius_a,
    input  logic        [31:0] i_mass_a,
    input  logic signed [31:0] i_pos_b_x,
    input  logic signed [31:0] i_pos_b_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic        [23:0] i_radius_b,
    input  logic        [31:0] i_mass_b,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_new_pos_a_x,
    input  logic signed [31:0] i_new_pos_a_y,
    input  logic signed [31:0] i_new_vel_a_x,
    input  logic signed [31:0] i_new_vel_a_y,
    input  logic signed [31:0] i_new_pos_b_x,
    input  logic signed [31:0] i_new_pos_b_y,
    input  logic signed [31:0] i_new_vel_b_x,
    input  logic signed [31:0] i_new_vel_b_y,
    input  logic               i_collided,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint NORM_ONE = 64'sd1 << 30;

    cpec_pkg::t_out expected_results[$];

    function automatic logic [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic longint clip_norm(input longint x);
        if (x > NORM_ONE) return NORM_ONE;
        if (x < -NORM_ONE) return -NORM_ONE;
        return x;
    endfunction

    function automatic longint root_floor(input longint v);
        longint res;
        longint bt;
        res = 0;
        bt = 64'sd1 << 60;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic cpec_pkg::t_out resolve_pair();
        longint pax, pay, vax, vay, pbx, pby, vbx, vby;
        longint ra, rb, ma, mb, dx, dy, r, d2, dlen, nx, ny, van, vbn, mt, ov, hx, hy;
        longint qa, qb, da, db;
        logic hit;
        cpec_pkg::t_out res;
        pax = i_pos_a_x; pay = i_pos_a_y; vax = i_vel_a_x; vay = i_vel_a_y;
        pbx = i_pos_b_x; pby = i_pos_b_y; vbx = i_vel_b_x; vby = i_vel_b_y;
        ra = longint'(i_radius_a); rb = longint'(i_radius_b);
        ma = longint'(i_mass_a); mb = longint'(i_mass_b);
        dx = pbx - pax;
        dy = pby - pay;
        r = ra + rb;
        hit = 1'b0;
        // Guard the squares with the box test so they never leave 64 bits.
        if ((dx < 0 ? -dx : dx) < r && (dy < 0 ? -dy : dy) < r) begin
            d2 = dx * dx + dy * dy;
            if (d2 != 0 && d2 < r * r) hit = 1'b1;
        end
        if (hit) begin
            dlen = root_floor(d2);
            nx = clip_norm((dx * NORM_ONE) / dlen);
            ny = clip_norm((dy * NORM_ONE) / dlen);
            van = clip32((vax * nx + vay * ny) >>> 30);
            van = longint'(signed'(van[31:0]));
            vbn = clip32((vbx * nx + vby * ny) >>> 30);
            vbn = longint'(signed'(vbn[31:0]));
            mt = ma + mb;
            ov = r - dlen;
            hx = (ov * nx) >>> 31;
            hy = (ov * ny) >>> 31;
            // Zero total mass leaves velocities alone; the push still applies.
            if (mt != 0) begin
                qb = ((2 * mb) << 30) / mt;
                qa = ((2 * ma) << 30) / mt;
                da = (qb * (vbn - van)) >>> 30;
                db = (qa * (van - vbn)) >>> 30;
                vax = vax + ((da * nx) >>> 30);
                vay = vay + ((da * ny) >>> 30);
                vbx = vbx + ((db * nx) >>> 30);
                vby = vby + ((db * ny) >>> 30);
            end
            pax = pax - hx; pay = pay - hy;
            pbx = pbx + hx; pby = pby + hy;
        end
        res.pax = clip32(pax); res.pay = clip32(pay);
        res.vax = clip32(vax); res.vay = clip32(vay);
        res.pbx = clip32(pbx); res.pby = clip32(pby);
        res.vbx = clip32(vbx); res.vby = clip32(vby);
        res.hit = hit;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        cpec_pkg::t_out exp_r;
        if (i_rst_n) begin
            if (i_valid && i_ready_in) expected_results.push_back(resolve_pair());
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("new_pos_a_x", exp_r.pax, i_new_pos_a_x);
                    check_field("new_pos_a_y", exp_r.pay, i_new_pos_a_y);
                    check_field("new_vel_a_x", exp_r.vax, i_new_vel_a_x);
                    check_field("new_vel_a_y", exp_r.vay, i_new_vel_a_y);
                    check_field("new_pos_b_x", exp_r.pbx, i_new_pos_b_x);
                    check_field("new_pos_b_y", exp_r.pby, i_new_pos_b_y);
                    check_field("new_vel_b_x", exp_r.vbx, i_new_vel_b_x);
                    check_field("new_vel_b_y", exp_r.vby, i_new_vel_b_y);
                    check_field("collided", {31'b0, exp_r.hit}, {31'b0, i_collided});
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

>>> verif/circle_pair_elastic_collision_core_tb.sv
// Top-level bench for the collision core: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module circle_pair_elastic_collision_core_tb;

    localparam int NUM_RANDOM = 1850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_pos_a_x, i_pos_a_y, i_vel_a_x, i_vel_a_y;
    logic        [23:0] i_radius_a;
    logic        [31:0] i_mass_a;
    logic signed [31:0] i_pos_b_x, i_pos_b_y, i_vel_b_x, i_vel_b_y;
    logic        [23:0] i_radius_b;
    logic        [31:0] i_mass_b;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_new_pos_a_x, o_new_pos_a_y, o_new_vel_a_x, o_new_vel_a_y;
    logic signed [31:0] o_new_pos_b_x, o_new_pos_b_y, o_new_vel_b_x, o_new_vel_b_y;
    logic               o_collided;

    int fail_count;
    int pending;
    int cycle_count;
    int results_seen;
    bit send_burst;   // when set, the sender offers back to back
    bit recv_burst;   // when set, the receiver skips its random hold-offs

    circle_pair_elastic_collision_core i_dut (.*);

    circle_pair_elastic_collision_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ready_in    (o_ready),
        .i_pos_a_x     (i_pos_a_x),
        .i_pos_a_y     (i_pos_a_y),
        .i_vel_a_x     (i_vel_a_x),
        .i_vel_a_y     (i_vel_a_y),
        .i_radius_a    (i_radius_a),
        .i_mass_a      (i_mass_a),
        .i_pos_b_x     (i_pos_b_x),
        .i_pos_b_y     (i_pos_b_y),
        .i_vel_b_x     (i_vel_b_x),
        .i_vel_b_y     (i_vel_b_y),
        .i_radius_b    (i_radius_b),
        .i_mass_b      (i_mass_b),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_new_pos_a_x (o_new_pos_a_x),
        .i_new_pos_a_y (o_new_pos_a_y),
        .i_new_vel_a_x (o_new_vel_a_x),
        .i_new_vel_a_y (o_new_vel_a_y),
        .i_new_pos_b_x (o_new_pos_b_x),
        .i_new_pos_b_y (o_new_pos_b_y),
        .i_new_vel_b_x (o_new_vel_b_x),
        .i_new_vel_b_y (o_new_vel_b_y),
        .i_collided    (o_collided),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one request: idle a random number of cycles unless in burst mode, then hold it until taken.
    task automatic send_pair(input logic signed [31:0] pax, pay, vax, vay,
                             input logic [23:0] ra, input logic [31:0] ma,
                             input logic signed [31:0] pbx, pby, vbx, vby,
                             input logic [23:0] rb, input logic [31:0] mb);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_pos_a_x = pax; i_pos_a_y = pay; i_vel_a_x = vax; i_vel_a_y = vay;
        i_radius_a = ra; i_mass_a = ma;
        i_pos_b_x = pbx; i_pos_b_y = pby; i_vel_b_x = vbx; i_vel_b_y = vby;
        i_radius_b = rb; i_mass_b = mb;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [23:0] pick_radius();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom_range(0, 24'hFF_FFFF));
            1:       return 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(0, 24'h0F_FFFF));
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(1, 32'h0001_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_speed();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF - $urandom_range(0, 32'h0100_0000);
            1:       return 32'h8000_0000 + $urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    // Random pair: mostly overlapping or near-overlapping circles, some pure noise.
    task automatic send_random_pair();
        logic [23:0] ra, rb;
        longint r, dx, dy;
        logic [31:0] pax, pay;
        if ($urandom_range(0, 9) < 2) begin
            send_pair($urandom, $urandom, $urandom, $urandom, 24'($urandom), $urandom,
                      $urandom, $urandom, $urandom, $urandom, 24'($urandom), $urandom);
        end else begin
            ra = pick_radius();
            rb = pick_radius();
            r = longint'(ra) + longint'(rb);
            dx = longint'($urandom_range(0, 32'(2 * r + 4))) - (r + 2);
            dy = longint'($urandom_range(0, 32'(2 * r + 4))) - (r + 2);
            pax = pick_base();
            pay = pick_base();
            send_pair(pax, pay, pick_speed(), pick_speed(), ra, pick_mass(),
                      pax + dx[31:0], pay + dy[31:0], pick_speed(), pick_speed(),
                      rb, pick_mass());
        end
    endtask

    // Receiver: random hold-offs per result unless in burst mode, one long hold-off to back up the pipe.
    initial begin
        int gap;
        i_ready = 1'b0;
        results_seen = 0;
        @(posedge i_rst_n);
        forever begin
            if (results_seen == 300) gap = LONG_HOLD;
            else gap = recv_burst ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            results_seen++;
            if (results_seen % 150 == 0) recv_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        int drain;
        cycle_count = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        i_valid = 1'b0;
        i_pos_a_x = '0; i_pos_a_y = '0; i_vel_a_x = '0; i_vel_a_y = '0;
        i_radius_a = '0; i_mass_a = '0;
        i_pos_b_x = '0; i_pos_b_y = '0; i_vel_b_x = '0; i_vel_b_y = '0;
        i_radius_b = '0; i_mass_b = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: coincident centres pass unchanged.
        send_pair(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000,
                  24'h01_0000, 32'h100,
                  32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000, 32'sh0000_8000,
                  24'h01_0000, 32'h100);
        // Exactly touching along x, then clearly apart.
        send_pair(0, 0, 32'sh0001_0000, 0, 24'h01_0000, 32'h100,
                  32'sh0002_0000, 0, -32'sh0001_0000, 0, 24'h01_0000, 32'h100);
        send_pair(0, 0, 32'sh0001_0000, 0, 24'h01_0000, 32'h100,
                  32'sh0005_0000, 0, -32'sh0001_0000, 0, 24'h01_0000, 32'h100);
        // Head-on overlap with equal masses, and a diagonal one with unequal masses.
        send_pair(0, 0, 32'sh0001_0000, 0, 24'h01_0000, 32'h100,
                  32'sh0001_8000, 0, -32'sh0001_0000, 0, 24'h01_0000, 32'h100);
        send_pair(0, 0, 32'sh0002_0000, 32'sh0001_0000, 24'h02_0000, 32'h300,
                  32'sh0001_0000, 32'sh0001_0000, 0, -32'sh0003_0000, 24'h01_0000, 32'h100);
        // Both masses zero: push only.
        send_pair(0, 0, 32'sh0001_0000, 0, 24'h01_0000, 32'h0,
                  32'sh0000_8000, 32'sh0000_4000, -32'sh0001_0000, 0, 24'h01_0000, 32'h0);
        // One mass zero.
        send_pair(0, 0, 32'sh0001_0000, 0, 24'h01_0000, 32'h0,
                  32'sh0000_8000, 0, -32'sh0001_0000, 0, 24'h01_0000, 32'h100);
        // Zero radii never collide.
        send_pair(0, 0, 1, 1, 24'h0, 32'h1, 1, 1, 2, 2, 24'h0, 32'h1);
        // Largest radii and masses, extreme velocities.
        send_pair(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hFF_FFFF, 32'hFFFF_FFFF,
                  32'sh0000_0001, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'hFF_FFFF,
                  32'hFFFF_FFFF);
        // Positions at the rails so the push saturates.
        send_pair(32'sh8000_0000, 32'sh8000_0000, 0, 0, 24'hFF_FFFF, 32'h100,
                  32'sh8000_0001, 32'sh8000_0001, 0, 0, 24'hFF_FFFF, 32'h100);
        send_pair(32'sh7FFF_FFFE, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  24'hFF_FFFF, 32'h1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 24'hFF_FFFF, 32'hFFFF_FFFF);
        // Distance one LSB, tiny radii.
        send_pair(0, 0, 32'sh0000_1000, 0, 24'h1, 32'h1,
                  0, 1, 0, -32'sh0000_1000, 24'h1, 32'h1);
        // Far apart in x with wrap-around difference.
        send_pair(32'sh7FFF_0000, 0, 0, 0, 24'hFF_FFFF, 32'h100,
                  32'sh8000_1000, 0, 0, 0, 24'hFF_FFFF, 32'h100);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 100 == 0) send_burst = ($urandom_range(0, 2) == 0);
            // Let the pipe drain completely once mid-run; drop the last request first.
            if (n == 1200) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                wait (pending == 0 && !o_valid);
            end
            send_random_pair();
        end
        @(negedge i_clk);
        i_valid = 1'b0;

        wait (pending == 0);
        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
